/* hw/rtl/flp_pkg.sv */
// Shared constants and coefficient ROM for the 39-tap low-pass FIR.
package flp_pkg;

    // Width of the sample and result ports (Q1.15)
    localparam int IO_W = 16;

    // Default configuration
    localparam int TAPS_DEF         = 39;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 16;

    // Hamming-windowed low-pass taps, Q1.15, round(c * 32768)
    localparam int ROM_TAPS = 39;
    localparam int LP_ROM [ROM_TAPS] = '{
        11, -34, -63, -33, 72, 170, 112, -149, -405, -308,
        247, 838, 740, -343, -1692, -1817, 412, 4609, 8766, 10503,
        8766, 4609, 412, -1817, -1692, -343, 740, 838, 247, -308,
        -405, -149, 112, 170, 72, -33, -63, -34, 11
    };

    // Coefficient n rescaled to Q1.(cw-1); taps past the ROM are zero.
    // Narrowing rounds half toward +infinity.
    function automatic int coef_at(input int n, input int cw);
        int c;
        c = 0;
        if (n >= 0 && n < ROM_TAPS)
            c = LP_ROM[n];
        if (cw >= 16)
            c = c <<< (cw - 16);
        else
            c = (c + (1 <<< (15 - cw))) >>> (16 - cw);
        return c;
    endfunction

endpackage

/* hw/rtl/flp_tap_cell.sv */
// One cell of the transposed-form FIR chain: multiply-add into a partial sum.
module flp_tap_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16,
    parameter int ACC_WIDTH    = 39,
    parameter logic signed [COEF_WIDTH-1:0] COEF = '0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic signed [ACC_WIDTH-1:0] part_in,
    output logic signed [ACC_WIDTH-1:0] part_out
);

    logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] prod;
    logic signed [ACC_WIDTH-1:0]               sum_reg;
    logic signed [ACC_WIDTH-1:0]               sum_next;

    // Tap product plus the partial sum handed down from the upstream cell
    always_comb
    begin
        prod     = x * COEF;
        sum_next = ACC_WIDTH'(prod) + part_in;
    end

    // Partial sum advances only when a new item enters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign part_out = sum_reg;

endmodule

/* hw/rtl/fir_lowpass_filter.sv */
// Top level of the 39-tap low-pass FIR: cell chain, rounding and output register.
// Path from item acceptance to out_valid: cell chain register, then round/saturate into the output register.
// Throughput: one item per cycle while in_stall is low; each cell does one multiply-add per accepted item.
// Backpressure on out_stall propagates to in_stall once the pending sum cannot move on.
// Reset clears every partial sum (equivalent to an all-zero delay line) and all valids.
module fir_lowpass_filter #(
    parameter int TAPS         = flp_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = flp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = flp_pkg::COEF_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [flp_pkg::IO_W-1:0]  sample_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [flp_pkg::IO_W-1:0]  filtered_out
);

    import flp_pkg::*;

    localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAPS) + 1;
    localparam logic signed [ACC_WIDTH-1:0] Y_MAX =
        (ACC_WIDTH'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] Y_MIN = -Y_MAX - ACC_WIDTH'(1);
    localparam logic signed [ACC_WIDTH-1:0] RND   = ACC_WIDTH'(1) <<< (COEF_WIDTH - 2);

    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [ACC_WIDTH-1:0]    part [TAPS+1];
    logic signed [ACC_WIDTH-1:0]    rounded;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    logic accept;
    logic advance;
    logic load_out;

    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    // Sample port to internal sample width
    generate
        if (SAMPLE_WIDTH <= IO_W)
        begin : g_in_narrow
            assign x = sample_in[SAMPLE_WIDTH-1:0];
        end
        else
        begin : g_in_wide
            assign x = {{(SAMPLE_WIDTH-IO_W){1'b0}}, sample_in};
        end
    endgenerate

    // Handshake: pending sum moves to the output register when that is free
    assign load_out = !out_valid_reg || !out_stall;
    assign advance  = pend_valid_reg && load_out;
    assign in_stall = pend_valid_reg && !load_out;
    assign accept   = in_valid && !in_stall;

    // Transposed-form chain; cell 0 holds the finished dot product
    assign part[TAPS] = '0;
    generate
        for (genvar k = 0; k < TAPS; k++)
        begin : g_cell
            flp_tap_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .COEF_WIDTH   (COEF_WIDTH),
                .ACC_WIDTH    (ACC_WIDTH),
                .COEF         (COEF_WIDTH'(coef_at(k, COEF_WIDTH)))
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (accept),
                .x        (x),
                .part_in  (part[k+1]),
                .part_out (part[k])
            );
        end
    endgenerate

    // Round half up, then saturate to the sample range
    always_comb
    begin
        rounded = (part[0] + RND) >>> (COEF_WIDTH - 1);
        if (rounded > Y_MAX)
            y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
        else if (rounded < Y_MIN)
            y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
        else
            y_sat = rounded[SAMPLE_WIDTH-1:0];
    end

    // Valid flags for the pending sum and the output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
            pend_valid_next = 1'b1;
        else if (advance)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= y_sat;
    end

    assign out_valid = out_valid_reg;

    // Internal sample width back to the port width
    generate
        if (SAMPLE_WIDTH >= IO_W)
        begin : g_out_wide
            assign filtered_out = out_data_reg[IO_W-1:0];
        end
        else
        begin : g_out_narrow
            assign filtered_out = {{(IO_W-SAMPLE_WIDTH){1'b0}}, out_data_reg};
        end
    endgenerate

endmodule
